// ===== sv/bb3ea_pkg.sv =====
package bb3ea_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WLEN_W = $clog2(MAX_WIDTH + 1);
    localparam int HLEN_W = $clog2(MAX_HEIGHT + 1);

    localparam int SIZE_W = 11;
    localparam int COORD_W = 10;
    localparam int CHAN_W = 8;
    localparam int PIX_W = 3 * CHAN_W;
    localparam int LINE_W = 2 * PIX_W;
    localparam int WIN_CELLS = 9;
    localparam int EMIT_W = 4;

    localparam int SUM_W = 12;
    localparam int CNT_W = 4;
    localparam int DIVIDEND_W = SUM_W + 1;
    localparam int RECIP_W = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W = DIVIDEND_W + RECIP_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t [WIN_CELLS-1:0] win;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [2:0]             row_ok;
        logic [2:0]             col_ok;
        logic [EMIT_W-1:0]      emit;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_PUSH
    } front_state_t;

    function automatic logic [WLEN_W-1:0] clamp_width(logic [SIZE_W-1:0] v);
        if (v == '0)
            return WLEN_W'(1);
        else if (32'(v) > MAX_WIDTH)
            return WLEN_W'(MAX_WIDTH);
        else
            return WLEN_W'(v);
    endfunction

    function automatic logic [HLEN_W-1:0] clamp_height(logic [SIZE_W-1:0] v);
        if (v == '0)
            return HLEN_W'(1);
        else if (32'(v) > MAX_HEIGHT)
            return HLEN_W'(MAX_HEIGHT);
        else
            return HLEN_W'(v);
    endfunction

    // ceil(2^18 / (2n)), exact for dividends below 2^13
    function automatic logic [RECIP_W-1:0] mean_recip(logic [CNT_W-1:0] n);
        case (n)
            4'd1:    return 18'd131072;
            4'd2:    return 18'd65536;
            4'd3:    return 18'd43691;
            4'd4:    return 18'd32768;
            4'd5:    return 18'd26215;
            4'd6:    return 18'd21846;
            4'd7:    return 18'd18725;
            4'd8:    return 18'd16384;
            4'd9:    return 18'd14564;
            default: return 18'd131072;
        endcase
    endfunction

endpackage

// ===== sv/bb3ea_ram.sv =====
module bb3ea_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bb3ea_queue.sv =====
module bb3ea_queue
    import bb3ea_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/bb3ea_front.sv =====
module bb3ea_front
    import bb3ea_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WLEN_W-1:0] width,
    input  logic [HLEN_W-1:0] height,
    input  logic              in_valid,
    output logic              in_ready,
    input  pixel_t            in_pixel,
    output logic              q_push,
    output job_t              q_job,
    input  logic              q_full
);

    front_state_t state_reg;
    front_state_t state_next;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] cur_col_reg;
    logic [ROW_W-1:0] cur_row_reg;
    pixel_t           pix_reg;
    pixel_t [WIN_CELLS-1:0] win_reg;
    pixel_t [WIN_CELLS-1:0] win_next;
    job_t             pend_reg;
    job_t             job_now;

    logic              wrap;
    logic [COL_W-1:0]  start_col;
    logic [ROW_W-1:0]  start_row;
    logic [LINE_W-1:0] line_rd;
    pixel_t            older_rd;
    pixel_t            newer_rd;
    logic              last_col;
    logic              last_row;
    logic              accept;
    logic [EMIT_W-1:0] emit;

    assign in_ready = (state_reg == F_IDLE);
    assign accept = in_valid && in_ready;

    // restart the frame if the size shrank under the counters
    assign wrap = (WLEN_W'(col_reg) >= width) || (HLEN_W'(row_reg) >= height);
    assign start_col = wrap ? '0 : col_reg;
    assign start_row = wrap ? '0 : row_reg;

    bb3ea_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (state_reg == F_READ),
        .waddr (cur_col_reg),
        .wdata ({newer_rd, pix_reg}),
        .raddr (start_col),
        .rdata (line_rd)
    );

    assign older_rd = line_rd[LINE_W-1:PIX_W];
    assign newer_rd = line_rd[PIX_W-1:0];

    assign last_col = (WLEN_W'(cur_col_reg) + WLEN_W'(1)) >= width;
    assign last_row = (HLEN_W'(cur_row_reg) + HLEN_W'(1)) >= height;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k * 3] = win_reg[k * 3 + 1];
            win_next[k * 3 + 1] = win_reg[k * 3 + 2];
        end
        win_next[2] = older_rd;
        win_next[5] = newer_rd;
        win_next[8] = pix_reg;
    end

    always_comb
    begin
        emit[0] = (cur_row_reg != '0) && (cur_col_reg != '0);
        emit[1] = (cur_row_reg != '0) && last_col;
        emit[2] = last_row && (cur_col_reg != '0);
        emit[3] = last_row && last_col;
        job_now.win = win_next;
        job_now.row = cur_row_reg;
        job_now.col = cur_col_reg;
        job_now.row_ok = {1'b1, cur_row_reg != '0, cur_row_reg > ROW_W'(1)};
        job_now.col_ok = {1'b1, cur_col_reg != '0, cur_col_reg > COL_W'(1)};
        job_now.emit = emit;
    end

    always_comb
    begin
        state_next = state_reg;
        q_push = 1'b0;
        q_job = job_now;
        col_next = col_reg;
        row_next = row_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_READ;
                end
            end
            F_READ:
            begin
                col_next = last_col ? '0 : cur_col_reg + 1'b1;
                if (last_col)
                begin
                    row_next = last_row ? '0 : cur_row_reg + 1'b1;
                end
                else
                begin
                    row_next = cur_row_reg;
                end
                if (emit == '0)
                begin
                    state_next = F_IDLE;
                end
                else if (!q_full)
                begin
                    q_push = 1'b1;
                    state_next = F_IDLE;
                end
                else
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                q_job = pend_reg;
                if (!q_full)
                begin
                    q_push = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_col_reg <= start_col;
            cur_row_reg <= start_row;
            pix_reg <= in_pixel;
        end
        if (state_reg == F_READ)
        begin
            win_reg <= win_next;
            pend_reg <= job_now;
        end
    end

endmodule

// ===== sv/bb3ea_back.sv =====
module bb3ea_back
    import bb3ea_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  job_t               q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output pixel_t             out_pixel,
    output logic [COORD_W-1:0] out_row,
    output logic [COORD_W-1:0] out_col,
    output logic               out_done
);

    logic [EMIT_W-1:0] sent_reg;
    logic [EMIT_W-1:0] sent_next;

    logic              a_valid_reg;
    logic [SUM_W-1:0]  a_red_reg;
    logic [SUM_W-1:0]  a_green_reg;
    logic [SUM_W-1:0]  a_blue_reg;
    logic [CNT_W-1:0]  a_n_reg;
    logic [ROW_W-1:0]  a_row_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic              a_done_reg;

    logic              o_valid_reg;
    pixel_t            o_pixel_reg;
    logic [ROW_W-1:0]  o_row_reg;
    logic [COL_W-1:0]  o_col_reg;
    logic              o_done_reg;

    logic              o_free;
    logic              a_free;
    logic              issue;
    logic [EMIT_W-1:0] left;
    logic [EMIT_W-1:0] pick;
    logic [1:0]        kind;
    logic [2:0]        row_mask;
    logic [2:0]        col_mask;
    logic [SUM_W-1:0]  sum_red;
    logic [SUM_W-1:0]  sum_green;
    logic [SUM_W-1:0]  sum_blue;
    logic [CNT_W-1:0]  num;
    logic [ROW_W-1:0]  ctr_row;
    logic [COL_W-1:0]  ctr_col;

    logic [RECIP_W-1:0]    recip;
    logic [DIVIDEND_W-1:0] dv_red;
    logic [DIVIDEND_W-1:0] dv_green;
    logic [DIVIDEND_W-1:0] dv_blue;
    logic [PROD_W-1:0]     pr_red;
    logic [PROD_W-1:0]     pr_green;
    logic [PROD_W-1:0]     pr_blue;

    assign o_free = !o_valid_reg || out_ready;
    assign a_free = !a_valid_reg || o_free;

    // results of one pixel go out in emit-bit order
    assign left = q_head.emit & ~sent_reg;
    assign pick = left & (~left + 1'b1);
    assign issue = !q_empty && a_free;
    assign q_pop = issue && ((sent_reg | pick) == q_head.emit);

    always_comb
    begin
        if (left[0])
            kind = 2'd0;
        else if (left[1])
            kind = 2'd1;
        else if (left[2])
            kind = 2'd2;
        else
            kind = 2'd3;
    end

    always_comb
    begin
        sent_next = sent_reg;
        if (q_pop)
        begin
            sent_next = '0;
        end
        else if (issue)
        begin
            sent_next = sent_reg | pick;
        end
    end

    // center one row or column lower drops the top row or left column
    always_comb
    begin
        row_mask = q_head.row_ok & (kind[1] ? 3'b110 : 3'b111);
        col_mask = q_head.col_ok & (kind[0] ? 3'b110 : 3'b111);
        sum_red = '0;
        sum_green = '0;
        sum_blue = '0;
        num = '0;
        for (int wr = 0; wr < 3; wr++)
        begin
            for (int wc = 0; wc < 3; wc++)
            begin
                if (row_mask[wr] && col_mask[wc])
                begin
                    sum_red = sum_red + SUM_W'(q_head.win[wr * 3 + wc].red);
                    sum_green = sum_green + SUM_W'(q_head.win[wr * 3 + wc].green);
                    sum_blue = sum_blue + SUM_W'(q_head.win[wr * 3 + wc].blue);
                    num = num + 1'b1;
                end
            end
        end
        ctr_row = kind[1] ? q_head.row : q_head.row - 1'b1;
        ctr_col = kind[0] ? q_head.col : q_head.col - 1'b1;
    end

    // round half up: (2*sum + n) / (2n) by reciprocal multiply
    always_comb
    begin
        recip = mean_recip(a_n_reg);
        dv_red = {a_red_reg, 1'b0} + DIVIDEND_W'(a_n_reg);
        dv_green = {a_green_reg, 1'b0} + DIVIDEND_W'(a_n_reg);
        dv_blue = {a_blue_reg, 1'b0} + DIVIDEND_W'(a_n_reg);
        pr_red = PROD_W'(dv_red) * PROD_W'(recip);
        pr_green = PROD_W'(dv_green) * PROD_W'(recip);
        pr_blue = PROD_W'(dv_blue) * PROD_W'(recip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= '0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg <= sent_next;
            if (a_free)
            begin
                a_valid_reg <= issue;
            end
            if (o_free)
            begin
                o_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_red_reg <= sum_red;
            a_green_reg <= sum_green;
            a_blue_reg <= sum_blue;
            a_n_reg <= num;
            a_row_reg <= ctr_row;
            a_col_reg <= ctr_col;
            a_done_reg <= (kind == 2'd3);
        end
        if (o_free && a_valid_reg)
        begin
            o_pixel_reg.red <= pr_red[RECIP_SHIFT +: CHAN_W];
            o_pixel_reg.green <= pr_green[RECIP_SHIFT +: CHAN_W];
            o_pixel_reg.blue <= pr_blue[RECIP_SHIFT +: CHAN_W];
            o_row_reg <= a_row_reg;
            o_col_reg <= a_col_reg;
            o_done_reg <= a_done_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_pixel = o_pixel_reg;
    assign out_row = COORD_W'(o_row_reg);
    assign out_col = COORD_W'(o_col_reg);
    assign out_done = o_done_reg;

endmodule

// ===== sv/box_blur_3x3_edge_aware.sv =====
// channel   dir  signals                                      moves
// cfg       in   cfg_we, cfg_index, cfg_data                  frame_width / frame_height write
// in        in   in_valid, in_ready, in_red/green/blue        one raster-order pixel request
// out       out  out_valid, out_ready, out_red/green/blue,    one blurred pixel request
//                out_row, out_col, frame_done
//
// front accepts a pixel, then does line-store read and window shift before taking another
// back sends one result per cycle unless out_ready stalls; an entry pops with its last result
// results from the queue head pass a sum stage, then a reciprocal multiply stage
// reset: sizes to 1024, counters to zero; line stores are not cleared
// a 2-entry queue between front and back lets each side stall alone
module box_blur_3x3_edge_aware
    import bb3ea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHAN_W-1:0]    in_red,
    input  logic [CHAN_W-1:0]    in_green,
    input  logic [CHAN_W-1:0]    in_blue,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAN_W-1:0]    out_red,
    output logic [CHAN_W-1:0]    out_green,
    output logic [CHAN_W-1:0]    out_blue,
    output logic [COORD_W-1:0]   out_row,
    output logic [COORD_W-1:0]   out_col,
    output logic                 frame_done
);

    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    logic [WLEN_W-1:0] width;
    logic [HLEN_W-1:0] height;

    pixel_t in_pixel;
    pixel_t out_pixel;
    job_t   push_job;
    job_t   head_job;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= SIZE_RESET;
            frame_height_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign width = clamp_width(frame_width_reg);
    assign height = clamp_height(frame_height_reg);

    assign in_pixel.red = in_red;
    assign in_pixel.green = in_green;
    assign in_pixel.blue = in_blue;

    bb3ea_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .width    (width),
        .height   (height),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_pixel (in_pixel),
        .q_push   (q_push),
        .q_job    (push_job),
        .q_full   (q_full)
    );

    bb3ea_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_job),
        .empty    (q_empty)
    );

    bb3ea_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (head_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_done  (frame_done)
    );

    assign out_red = out_pixel.red;
    assign out_green = out_pixel.green;
    assign out_blue = out_pixel.blue;

endmodule
